>>> sv/fq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fq_pkg
// Shared types and constants for the FIFO queue with search and replace.
// ----------------------------------------------------------------------------
package fq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;
  localparam int ACTION_W      = 3;
  localparam int STATUS_W      = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_DELETE  = 3'd1,
    ACT_PEEK    = 3'd2,
    ACT_DISPLAY = 3'd3,
    ACT_CHANGE  = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage

>>> sv/fq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fq_in_if / fq_out_if
// Valid/ready channels for queue commands and queue responses.
// ----------------------------------------------------------------------------
interface fq_in_if;
  logic                                valid;
  logic                                ready;
  logic [fq_pkg::ACTION_W-1:0]         action;
  logic signed [fq_pkg::DATA_W-1:0]    value;
  logic signed [fq_pkg::DATA_W-1:0]    new_value;

  modport source (output valid, output action, output value, output new_value,
                  input ready);
  modport sink   (input valid, input action, input value, input new_value,
                  output ready);
endinterface

interface fq_out_if;
  logic                                valid;
  logic                                ready;
  logic [fq_pkg::STATUS_W-1:0]         status;
  logic signed [fq_pkg::DATA_W-1:0]    data;
  logic                                last;

  modport source (output valid, output status, output data, output last,
                  input ready);
  modport sink   (input valid, input status, input data, input last,
                  output ready);
endinterface

>>> sv/fq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fq_ram
// Ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fq_ram #(
  parameter int DEPTH = fq_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic [fq_pkg::DATA_W-1:0]     wdata,
  input  logic                          re,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [fq_pkg::DATA_W-1:0]     rdata
);
  import fq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/fifo_queue_with_search_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_search_replace
// Bounded FIFO of 32-bit words in a ring memory, with peek, display and
// in-place search and replace.
// ----------------------------------------------------------------------------
// One command is handled at a time; cmd.ready is high only while the
// sequencer is idle, and a finished response sits in an output register so
// the next command can be taken while it waits. Insert answers at once;
// delete and peek first read the front word; display sends one response
// per stored word, front to back, with rsp.last on the last; change scans
// from the front and overwrites the first match, or reports not found. On
// an empty queue those four answer ST_EMPTY at once. Unused action codes get
// no response. Responses wait while rsp.ready is low. The ring memory has a
// single read port with registered read data, returning one word per cycle.
// The memory needs no clearing pass: only live entries are read.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_replace #(
  parameter int DEPTH = fq_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  fq_in_if.sink     cmd,
  fq_out_if.source  rsp
);
  import fq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_RESP,
    S_SHOW,
    S_SCAN
  } state_t;

  state_t              state;
  logic [AW-1:0]       head;
  logic [AW-1:0]       tail;
  logic [CW-1:0]       count;
  logic [AW-1:0]       pos;
  logic [CW-1:0]       seen;
  logic [DATA_W-1:0]   search;
  logic [DATA_W-1:0]   repl;
  status_t             res_status;
  logic [DATA_W-1:0]   res_data;

  logic                out_valid;
  status_t             out_status;
  logic [DATA_W-1:0]   out_data;
  logic                out_last;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [DATA_W-1:0]   wdata;
  logic                re;
  logic [AW-1:0]       raddr;
  logic [DATA_W-1:0]   rd_data;

  logic                slot_free;
  logic                out_load;
  logic                q_full;
  logic                q_empty;
  logic                at_back;
  logic                hit;

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  fq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign slot_free = !out_valid || rsp.ready;
  assign out_load  = slot_free && ((state == S_RESP) || (state == S_SHOW));
  assign q_full    = (count == CW'(DEPTH));
  assign q_empty   = (count == '0);
  assign at_back   = ((seen + 1'b1) == count);
  assign hit       = (rd_data == search);

  assign cmd.ready  = (state == S_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.data   = out_data;
  assign rsp.last   = out_last;

  // memory port steering; accesses never overlap since one command runs at a time
  always_comb begin
    we    = 1'b0;
    waddr = tail;
    wdata = cmd.value;
    re    = 1'b0;
    raddr = head;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          case (action_t'(cmd.action))
            ACT_INSERT: we = !q_full;
            ACT_DELETE, ACT_PEEK, ACT_DISPLAY, ACT_CHANGE: re = !q_empty;
            default: ;
          endcase
        end
      end
      S_SHOW: begin
        if (slot_free && !at_back) begin
          re    = 1'b1;
          raddr = next_pos(pos);
        end
      end
      S_SCAN: begin
        if (hit) begin
          we    = 1'b1;
          waddr = pos;
          wdata = repl;
        end else if (!at_back) begin
          re    = 1'b1;
          raddr = next_pos(pos);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            pos        <= head;
            seen       <= '0;
            search     <= cmd.value;
            repl       <= cmd.new_value;
            res_data   <= '0;
            res_status <= (action_t'(cmd.action) == ACT_INSERT) ?
                          (q_full ? ST_FULL : ST_OK) :
                          (q_empty ? ST_EMPTY : ST_OK);
            case (action_t'(cmd.action))
              ACT_INSERT: begin
                if (!q_full) begin
                  tail  <= next_pos(tail);
                  count <= count + 1'b1;
                end
                state <= S_RESP;
              end
              ACT_DELETE: begin
                if (q_empty) begin
                  state <= S_RESP;
                end else begin
                  head  <= next_pos(head);
                  count <= count - 1'b1;
                  state <= S_FETCH;
                end
              end
              ACT_PEEK:    state <= q_empty ? S_RESP : S_FETCH;
              ACT_DISPLAY: state <= q_empty ? S_RESP : S_SHOW;
              ACT_CHANGE:  state <= q_empty ? S_RESP : S_SCAN;
              default:     state <= S_IDLE;
            endcase
          end
        end
        S_FETCH: begin
          res_data <= rd_data;
          state    <= S_RESP;
        end
        S_RESP: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_data   <= res_data;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_SHOW: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_status <= ST_OK;
            out_data   <= rd_data;
            out_last   <= at_back;
            if (at_back) begin
              state <= S_IDLE;
            end else begin
              pos  <= next_pos(pos);
              seen <= seen + 1'b1;
            end
          end
        end
        S_SCAN: begin
          // rd_data holds the word at pos
          if (hit) begin
            res_status <= ST_OK;
            state      <= S_RESP;
          end else if (at_back) begin
            res_status <= ST_NOTFOUND;
            state      <= S_RESP;
          end else begin
            pos  <= next_pos(pos);
            seen <= seen + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
